### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked outside reset
`define HSTM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hstm assertion failed");

// implication checked on every edge, reset included
`define HSTM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("hstm assertion failed");

`endif

### sv/hstm_pkg.sv
// ---------------------------------------------------------------------------
// hstm_pkg
// widths, constants, register indexes and types of the sky tone mapper
// ---------------------------------------------------------------------------
`default_nettype none
package hstm_pkg;

    localparam int ACC_W      = 16;
    localparam int ROW_W      = 12;
    localparam int SKY_W      = 10;
    localparam int KNEE_W     = 12;
    localparam int HGT_W      = 13;
    localparam int OUT_W      = 8;
    localparam int MAX_HEIGHT = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_TOP_RED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_GREEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_BLUE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOT_RED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOT_GREEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOT_BLUE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KNEE       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd7;

    localparam logic [KNEE_W-1:0] KNEE_RESET   = 12'd256;
    localparam logic [HGT_W-1:0]  HEIGHT_RESET = 13'd480;

    // sky interpolation
    localparam int PROD_W = SKY_W + HGT_W;
    localparam int NUM_W  = 22;

    // tone curve
    localparam int X_W     = 25;
    localparam int H1_W    = 20;
    localparam int H2_W    = 28;
    localparam int H3_W    = 36;
    localparam int SPLIT_W = 18;
    localparam int PP_W    = X_W + SPLIT_W;
    localparam int SUM_W   = PP_W + SPLIT_W + 1;
    localparam int S_W     = 44;
    localparam int Q_W     = 25;
    localparam int Q_FRAC  = 24;

    localparam logic [X_W-1:0] X_LIMIT   = 25'h100_0000;
    localparam int             C_24TH    = 2731;
    localparam int             C_SIXTH   = 10923;
    localparam int             C_HALF    = 32768;
    localparam int             C_ONE     = 65536;
    localparam int             RECIP_REM = 32768;

    localparam int SKY_LAT  = 2 + SKY_W;
    localparam int TONE_LAT = 8 + Q_W;
    localparam int LANE_LAT = SKY_LAT + TONE_LAT;

    localparam int NUM_CH = 3;

    typedef struct packed {
        logic [SKY_W-1:0] top;
        logic [SKY_W-1:0] bot;
        logic [HGT_W-1:0] height;
    } t_sky_cfg;

endpackage
`default_nettype wire

### sv/hstm_sky.sv
// ---------------------------------------------------------------------------
// hstm_sky
// one channel lane: row interpolated sky colour with a pipelined divider
// ---------------------------------------------------------------------------
`default_nettype none
module hstm_sky
    import hstm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_sky_cfg         i_cfg,
    input  wire logic [ACC_W-1:0] i_acc,
    input  wire logic [HGT_W-1:0] i_row,
    output logic      [SKY_W-1:0] o_sky,
    output logic      [ACC_W-1:0] o_acc
);

    logic [HGT_W-1:0]  rest;
    logic [PROD_W-1:0] r_ptop;
    logic [PROD_W-1:0] r_pbot;
    logic [ACC_W-1:0]  r_acc1;
    logic [ACC_W-1:0]  r_acc2;
    logic [NUM_W-1:0]  r_num;
    logic [NUM_W-1:0]  r_rem [SKY_W];
    logic [SKY_W-1:0]  r_q   [SKY_W];
    logic [ACC_W-1:0]  r_acc [SKY_W];

    assign rest = i_cfg.height - i_row;

    always_ff @(posedge i_clk) begin
        r_ptop <= PROD_W'(i_cfg.top) * PROD_W'(rest);
        r_pbot <= PROD_W'(i_cfg.bot) * PROD_W'(i_row);
        r_acc1 <= i_acc;
        r_num  <= NUM_W'(r_ptop + r_pbot);
        r_acc2 <= r_acc1;
    end

    // one quotient bit per stage
    for (genvar j = 0; j < SKY_W; j++) begin : g_div
        logic [NUM_W-1:0] rem_in;
        logic [SKY_W-1:0] q_in;
        logic [ACC_W-1:0] acc_in;
        logic [NUM_W-1:0] dv;

        if (j == 0) begin : g_first
            assign rem_in = r_num;
            assign q_in   = '0;
            assign acc_in = r_acc2;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign q_in   = r_q[j-1];
            assign acc_in = r_acc[j-1];
        end

        assign dv = NUM_W'(i_cfg.height) << (SKY_W - 1 - j);

        always_ff @(posedge i_clk) begin
            r_acc[j] <= acc_in;
            if (rem_in >= dv) begin
                r_rem[j] <= rem_in - dv;
                r_q[j]   <= q_in | (SKY_W'(1) << (SKY_W - 1 - j));
            end else begin
                r_rem[j] <= rem_in;
                r_q[j]   <= q_in;
            end
        end
    end

    assign o_sky = r_q[SKY_W-1];
    assign o_acc = r_acc[SKY_W-1];

endmodule
`default_nettype wire

### sv/hstm_tone.sv
// ---------------------------------------------------------------------------
// hstm_tone
// one channel lane: knee gain, series shoulder and reciprocal divider
// ---------------------------------------------------------------------------
`default_nettype none
module hstm_tone
    import hstm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic [KNEE_W-1:0] i_knee,
    input  wire logic [ACC_W-1:0]  i_acc,
    input  wire logic [SKY_W-1:0]  i_sky,
    output logic      [OUT_W-1:0]  o_byte
);

    logic [ACC_W:0]          vsum;
    logic [ACC_W-1:0]        r_v;
    logic [ACC_W+KNEE_W-1:0] xprod;
    logic [X_W-1:0]          r_x0;
    logic [X_W-1:0]          r_x1;
    logic [X_W-1:0]          r_x2;
    logic [X_W-1:0]          r_x3;
    logic [X_W+KNEE_W-1:0]   p1;
    logic [X_W+H1_W-1:0]     p2;
    logic [X_W+H2_W-1:0]     p3;
    logic [H1_W-1:0]         r_h1;
    logic [H2_W-1:0]         r_h2;
    logic [H3_W-1:0]         r_h3;
    logic [PP_W-1:0]         r_plo;
    logic [PP_W-1:0]         r_phi;
    logic [SUM_W-1:0]        psum;
    logic [S_W-1:0]          r_s;
    logic [S_W-1:0]          r_rem [Q_W];
    logic [S_W-1:0]          r_sp  [Q_W];
    logic [Q_W-1:0]          r_q   [Q_W];
    logic [Q_W-1:0]          inv;
    logic [32:0]             scaled;
    logic [OUT_W-1:0]        r_byte;

    assign vsum  = {1'b0, i_acc} + (ACC_W+1)'(i_sky);
    assign xprod = (ACC_W+KNEE_W)'(r_v) * (ACC_W+KNEE_W)'(i_knee);
    assign p1    = (X_W+KNEE_W)'(r_x0) * (X_W+KNEE_W)'(C_24TH);
    assign p2    = (X_W+H1_W)'(r_x1) * (X_W+H1_W)'(r_h1);
    assign p3    = (X_W+H2_W)'(r_x2) * (X_W+H2_W)'(r_h2);
    assign psum  = {r_phi, {SPLIT_W{1'b0}}} + SUM_W'(r_plo);

    always_ff @(posedge i_clk) begin
        r_v   <= vsum[ACC_W] ? {ACC_W{1'b1}} : vsum[ACC_W-1:0];
        r_x0  <= (xprod > (ACC_W+KNEE_W)'(X_LIMIT)) ? X_LIMIT : xprod[X_W-1:0];
        r_h1  <= H1_W'(C_SIXTH) + H1_W'(p1 >> 16);
        r_x1  <= r_x0;
        r_h2  <= H2_W'(C_HALF) + H2_W'(p2 >> 16);
        r_x2  <= r_x1;
        r_h3  <= H3_W'(C_ONE) + H3_W'(p3 >> 16);
        r_x3  <= r_x2;
        r_plo <= PP_W'(r_x3) * PP_W'(r_h3[SPLIT_W-1:0]);
        r_phi <= PP_W'(r_x3) * PP_W'(r_h3[H3_W-1:SPLIT_W]);
        r_s   <= S_W'(C_ONE) + S_W'(psum >> 16);
    end

    // restoring division of 2^40 by the series sum, one bit per stage
    for (genvar j = 0; j < Q_W; j++) begin : g_recip
        logic [S_W-1:0] rem_in;
        logic [S_W-1:0] s_in;
        logic [Q_W-1:0] q_in;
        logic [S_W:0]   trial;

        if (j == 0) begin : g_first
            assign rem_in = S_W'(RECIP_REM);
            assign s_in   = r_s;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign s_in   = r_sp[j-1];
            assign q_in   = r_q[j-1];
        end

        assign trial = {rem_in, 1'b0};

        always_ff @(posedge i_clk) begin
            r_sp[j] <= s_in;
            if (trial >= {1'b0, s_in}) begin
                r_rem[j] <= S_W'(trial - {1'b0, s_in});
                r_q[j]   <= {q_in[Q_W-2:0], 1'b1};
            end else begin
                r_rem[j] <= trial[S_W-1:0];
                r_q[j]   <= {q_in[Q_W-2:0], 1'b0};
            end
        end
    end

    assign inv    = (Q_W'(1) << Q_FRAC) - r_q[Q_W-1];
    assign scaled = {inv, 8'd0} - 33'(inv);

    always_ff @(posedge i_clk) begin
        r_byte <= scaled[31:24];
    end

    assign o_byte = r_byte;

endmodule
`default_nettype wire

### sv/hdr_sky_tone_map.sv
// o_valid: the accepting edge of start runs down the r_vld delay line into r_out_vld
// throughput: one pixel per clock, busy stays low
// the delay line matches the 10-step sky divider and 25-step reciprocal divider
// pipelines in each of the three channel lanes
// reset: config registers return to defaults, transactions in flight are dropped
// the receiver cannot stall, each result shows for exactly one cycle
// ---------------------------------------------------------------------------
// hdr_sky_tone_map
// exponential tone mapping of accumulated light over a vertical sky gradient
// ---------------------------------------------------------------------------
`default_nettype none
module hdr_sky_tone_map
    import hstm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [ACC_W-1:0]      i_acc_red,
    input  wire logic [ACC_W-1:0]      i_acc_green,
    input  wire logic [ACC_W-1:0]      i_acc_blue,
    input  wire logic [ROW_W-1:0]      i_row_index,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_valid,
    output logic      [OUT_W-1:0]      o_out_red,
    output logic      [OUT_W-1:0]      o_out_green,
    output logic      [OUT_W-1:0]      o_out_blue
);

    logic [SKY_W-1:0]    r_top [NUM_CH];
    logic [SKY_W-1:0]    r_bot [NUM_CH];
    logic [KNEE_W-1:0]   r_knee;
    logic [HGT_W-1:0]    r_height;
    logic [HGT_W-1:0]    height;
    logic [HGT_W-1:0]    row;
    logic [LANE_LAT-1:0] r_vld;
    logic [LANE_LAT-1:0] n_vld;
    logic                r_out_vld;
    logic [OUT_W-1:0]    r_out [NUM_CH];
    logic [ACC_W-1:0]    acc_in [NUM_CH];
    logic [SKY_W-1:0]    lane_sky [NUM_CH];
    logic [ACC_W-1:0]    lane_acc [NUM_CH];
    logic [OUT_W-1:0]    lane_byte [NUM_CH];
    t_sky_cfg            sky_cfg [NUM_CH];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_top[c] <= '0;
                r_bot[c] <= '0;
            end
            r_knee   <= KNEE_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TOP_RED:   r_top[0] <= i_cfg_data[SKY_W-1:0];
                REG_TOP_GREEN: r_top[1] <= i_cfg_data[SKY_W-1:0];
                REG_TOP_BLUE:  r_top[2] <= i_cfg_data[SKY_W-1:0];
                REG_BOT_RED:   r_bot[0] <= i_cfg_data[SKY_W-1:0];
                REG_BOT_GREEN: r_bot[1] <= i_cfg_data[SKY_W-1:0];
                REG_BOT_BLUE:  r_bot[2] <= i_cfg_data[SKY_W-1:0];
                REG_KNEE:      r_knee   <= i_cfg_data[KNEE_W-1:0];
                REG_HEIGHT:    r_height <= i_cfg_data[HGT_W-1:0];
            endcase
        end
    end

    always_comb begin
        priority if (r_height == '0) begin
            height = HGT_W'(1);
        end else if (r_height > HGT_W'(MAX_HEIGHT)) begin
            height = HGT_W'(MAX_HEIGHT);
        end else begin
            height = r_height;
        end
        row = ({1'b0, i_row_index} > height) ? height : {1'b0, i_row_index};
    end

    assign acc_in[0] = i_acc_red;
    assign acc_in[1] = i_acc_green;
    assign acc_in[2] = i_acc_blue;

    for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
        assign sky_cfg[c] = '{top: r_top[c], bot: r_bot[c], height: height};

        hstm_sky u_sky (
            .i_clk (i_clk),
            .i_cfg (sky_cfg[c]),
            .i_acc (acc_in[c]),
            .i_row (row),
            .o_sky (lane_sky[c]),
            .o_acc (lane_acc[c])
        );

        hstm_tone u_tone (
            .i_clk  (i_clk),
            .i_knee (r_knee),
            .i_acc  (lane_acc[c]),
            .i_sky  (lane_sky[c]),
            .o_byte (lane_byte[c])
        );
    end

    assign n_vld = {r_vld[LANE_LAT-2:0], start & ~busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= n_vld;
            r_out_vld <= r_vld[LANE_LAT-1];
        end
    end

    // merge the three lanes into one result
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NUM_CH; c++) begin
            r_out[c] <= lane_byte[c];
        end
    end

    assign o_valid     = r_out_vld;
    assign o_out_red   = r_out[0];
    assign o_out_green = r_out[1];
    assign o_out_blue  = r_out[2];

endmodule
`default_nettype wire

### sv/hstm_checker.sv
// ---------------------------------------------------------------------------
// hstm_checker
// port level checks of the sky tone mapper, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module hstm_checker
    import hstm_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid
);

    `HSTM_ASSERT(a_never_busy, i_clk, i_rst_n, !busy)
    `HSTM_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_valid)
    `HSTM_ASSERT(a_latency, i_clk, i_rst_n, (start && !busy) |-> ##46 o_valid)

endmodule

bind hdr_sky_tone_map hstm_checker u_hstm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the sky tone mapper: a directed table, then
// random pixels over several register settings, each transaction checked
// against its typed bytes or a fixed point predictor of the exponential shoulder
// ---------------------------------------------------------------------------
`default_nettype none
module tb_top;
    import hstm_pkg::*;

    localparam int SETTLE    = 60;
    localparam int WDOG_MAX  = 5000;
    localparam int SHOW_MAX  = 10;

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } t_rgb_byte;

    typedef struct {
        logic [ACC_W-1:0] red;
        logic [ACC_W-1:0] green;
        logic [ACC_W-1:0] blue;
        logic [ROW_W-1:0] row;
        bit               typed;
        t_rgb_byte        want;
    } t_pixel_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [ACC_W-1:0]      i_acc_red = '0;
    logic [ACC_W-1:0]      i_acc_green = '0;
    logic [ACC_W-1:0]      i_acc_blue = '0;
    logic [ROW_W-1:0]      i_row_index = '0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_valid;
    logic [OUT_W-1:0]      o_out_red;
    logic [OUT_W-1:0]      o_out_green;
    logic [OUT_W-1:0]      o_out_blue;

    hdr_sky_tone_map dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_acc_red   (i_acc_red),
        .i_acc_green (i_acc_green),
        .i_acc_blue  (i_acc_blue),
        .i_row_index (i_row_index),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the register file
    logic [SKY_W-1:0]  sky_top [NUM_CH];
    logic [SKY_W-1:0]  sky_bot [NUM_CH];
    logic [KNEE_W-1:0] knee;
    logic [HGT_W-1:0]  height;

    t_rgb_byte pending_pixels[$];
    int        mismatches = 0;
    int        idle_pct   = 0;
    int        quiet_cycles = 0;
    bit        accepted_now;

    function automatic logic [OUT_W-1:0] shoulder(longint unsigned x);
        longint unsigned h;
        longint unsigned s;
        longint unsigned recip;
        if (x > 64'd16777216) x = 64'd16777216;
        h = C_24TH;
        h = C_SIXTH + ((x * h) >> 16);
        h = C_HALF + ((x * h) >> 16);
        h = C_ONE + ((x * h) >> 16);
        if (h >= (64'd1 << 40)) return 8'd255;
        s = C_ONE + ((x * h) >> 16);
        recip = (64'd1 << 40) / s;
        if (recip > (64'd1 << 24)) recip = 64'd1 << 24;
        return OUT_W'((64'd255 * ((64'd1 << 24) - recip)) >> 24);
    endfunction

    function automatic t_rgb_byte tone_map_pixel(logic [ACC_W-1:0] acc [NUM_CH],
                                                 logic [ROW_W-1:0] row_in);
        longint unsigned hgt;
        longint unsigned row;
        longint unsigned sky;
        longint unsigned v;
        logic [OUT_W-1:0] ch [NUM_CH];
        hgt = height;
        row = row_in;
        if (hgt < 1) hgt = 1;
        if (hgt > MAX_HEIGHT) hgt = MAX_HEIGHT;
        if (row > hgt) row = hgt;
        for (int c = 0; c < NUM_CH; c++) begin
            sky = (64'(sky_top[c]) * (hgt - row) + 64'(sky_bot[c]) * row) / hgt;
            v = acc[c] + sky;
            if (v > 64'hFFFF) v = 64'hFFFF;
            ch[c] = shoulder(v * knee);
        end
        return '{red: ch[0], green: ch[1], blue: ch[2]};
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_TOP_RED:   sky_top[0] = val[SKY_W-1:0];
            REG_TOP_GREEN: sky_top[1] = val[SKY_W-1:0];
            REG_TOP_BLUE:  sky_top[2] = val[SKY_W-1:0];
            REG_BOT_RED:   sky_bot[0] = val[SKY_W-1:0];
            REG_BOT_GREEN: sky_bot[1] = val[SKY_W-1:0];
            REG_BOT_BLUE:  sky_bot[2] = val[SKY_W-1:0];
            REG_KNEE:      knee       = val[KNEE_W-1:0];
            REG_HEIGHT:    height     = val[HGT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_all(logic [SKY_W-1:0] top [NUM_CH], logic [SKY_W-1:0] bot [NUM_CH],
                             logic [KNEE_W-1:0] k, logic [HGT_W-1:0] hg);
        drain();
        write_reg(REG_TOP_RED, CFG_DATA_W'(top[0]));
        write_reg(REG_TOP_GREEN, CFG_DATA_W'(top[1]));
        write_reg(REG_TOP_BLUE, CFG_DATA_W'(top[2]));
        write_reg(REG_BOT_RED, CFG_DATA_W'(bot[0]));
        write_reg(REG_BOT_GREEN, CFG_DATA_W'(bot[1]));
        write_reg(REG_BOT_BLUE, CFG_DATA_W'(bot[2]));
        write_reg(REG_KNEE, CFG_DATA_W'(k));
        write_reg(REG_HEIGHT, hg);
    endtask

    // drives one pixel and returns after the accepting edge
    task automatic send_pixel(t_pixel_row px);
        logic [ACC_W-1:0] acc [NUM_CH];
        while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_acc_red   <= px.red;
        i_acc_green <= px.green;
        i_acc_blue  <= px.blue;
        i_row_index <= px.row;
        do @(posedge i_clk); while (busy);
        acc[0] = px.red;
        acc[1] = px.green;
        acc[2] = px.blue;
        pending_pixels.push_back(px.typed ? px.want : tone_map_pixel(acc, px.row));
    endtask

    function automatic logic [ACC_W-1:0] rand_light();
        case ($urandom_range(3, 0))
            0: return ACC_W'($urandom);
            1: return ACC_W'($urandom_range(255, 0));
            default: return ACC_W'($urandom_range(2047, 0));
        endcase
    endfunction

    task automatic random_pixels(int count);
        t_pixel_row px;
        int lim;
        for (int n = 0; n < count; n++) begin
            lim = (height == 0) ? 1 : (height > MAX_HEIGHT ? MAX_HEIGHT : height);
            px.red   = rand_light();
            px.green = rand_light();
            px.blue  = rand_light();
            if ($urandom_range(9, 0) == 0) px.row = ROW_W'($urandom);
            else px.row = ROW_W'($urandom_range((lim + 1 > 4095) ? 4095 : lim + 1, 0));
            px.typed = 1'b0;
            px.want  = '0;
            send_pixel(px);
        end
        start <= 1'b0;
    endtask

    task automatic random_setting();
        logic [SKY_W-1:0] top [NUM_CH];
        logic [SKY_W-1:0] bot [NUM_CH];
        for (int c = 0; c < NUM_CH; c++) begin
            top[c] = SKY_W'($urandom);
            bot[c] = SKY_W'($urandom);
        end
        write_all(top, bot, KNEE_W'($urandom_range(600, 1)), HGT_W'($urandom_range(700, 1)));
    endtask

    t_pixel_row directed [] = '{
        '{16'h0000, 16'h0000, 16'h0000, 12'd0,    1'b1, '{8'd0,   8'd0,   8'd0}},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 12'd4095, 1'b1, '{8'd255, 8'd255, 8'd255}},
        '{16'hFFFF, 16'h0000, 16'hFFFF, 12'd0,    1'b1, '{8'd255, 8'd0,   8'd255}},
        '{16'h0100, 16'h0080, 16'h0040, 12'd0,    1'b0, '0},
        '{16'h0001, 16'h0010, 16'h0200, 12'd240,  1'b0, '0},
        '{16'h0300, 16'h0400, 16'h0500, 12'd479,  1'b0, '0},
        '{16'hAAAA, 16'h5555, 16'h00AA, 12'd480,  1'b0, '0},
        '{16'h5555, 16'hAAAA, 16'h0055, 12'd481,  1'b0, '0},
        '{16'h00FF, 16'h01FF, 16'h007F, 12'hAAA,  1'b0, '0},
        '{16'h0180, 16'h0001, 16'h0600, 12'h555,  1'b0, '0}
    };

    initial begin
        logic [SKY_W-1:0] top [NUM_CH];
        logic [SKY_W-1:0] bot [NUM_CH];
        for (int c = 0; c < NUM_CH; c++) begin
            sky_top[c] = '0;
            sky_bot[c] = '0;
        end
        knee   = KNEE_RESET;
        height = HEIGHT_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) send_pixel(directed[k]);
        start <= 1'b0;

        // full sky, zero knee, zero height
        top = '{10'd1023, 10'd1023, 10'd1023};
        bot = '{10'd0, 10'd0, 10'd0};
        write_all(top, bot, 12'd0, 13'd0);
        send_pixel('{16'hFFFF, 16'h1234, 16'h0000, 12'd0, 1'b1, '{8'd0, 8'd0, 8'd0}});
        random_pixels(8);

        // largest knee, height past the limit
        top = '{10'd0, 10'd512, 10'd1023};
        bot = '{10'd1023, 10'd256, 10'd0};
        write_all(top, bot, 12'd4095, 13'd8191);
        random_pixels(20);

        // smallest knee, one row picture
        write_all(top, bot, 12'd1, 13'd1);
        random_pixels(20);

        idle_pct = 9;
        random_setting();
        random_pixels(100);
        drain();
        random_pixels(100);

        idle_pct = 49;
        random_setting();
        random_pixels(180);

        idle_pct = 0;
        write_all(bot, top, 12'd4095, 13'd4096);
        random_pixels(40);
        random_setting();
        random_pixels(140);

        drain();
        if (pending_pixels.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("hdr_sky_tone_map regression: pass");
        end else begin
            $display("hdr_sky_tone_map regression: fail");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        t_rgb_byte want;
        accepted_now = start && !busy;
        if (i_rst_n && o_valid) begin
            accepted_now = 1'b1;
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_MAX) $display("unexpected transaction %0t", $realtime);
            end else begin
                want = pending_pixels.pop_front();
                if (want.red !== o_out_red || want.green !== o_out_green ||
                    want.blue !== o_out_blue) begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display("mismatch %0t: exp %0d %0d %0d got %0d %0d %0d",
                                 $realtime, want.red, want.green, want.blue,
                                 o_out_red, o_out_green, o_out_blue);
                end
            end
        end
        if (accepted_now || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= WDOG_MAX) begin
            $display("hdr_sky_tone_map regression: fail");
            $finish;
        end
    end

endmodule
`default_nettype wire

### sim.f
+incdir+sv
sv/hstm_pkg.sv
sv/hstm_sky.sv
sv/hstm_tone.sv
sv/hdr_sky_tone_map.sv
sv/hstm_checker.sv
bench/tb_top.sv
